### design/fir_filter_pcm16_assert.svh
// Assertion helpers shared by the RTL; clk and rst_n must be in scope.
`ifndef FIR_FILTER_PCM16_ASSERT_SVH
`define FIR_FILTER_PCM16_ASSERT_SVH

// same-cycle implication
`define FIR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FIR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fir_pcm_pkg.sv
`default_nettype none

package fir_pcm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS = 15;
  localparam int TCNT_W    = 6;
  localparam int TIDX_W    = 5;

  localparam logic CMD_WRITE_COEF = 1'b0;
  localparam logic CMD_FILTER     = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // control from sequencer to the MAC
  typedef struct packed {
    logic clr;  // zero the accumulator
    logic vld;  // operands valid this cycle
  } mac_ctrl_t;

endpackage

`default_nettype wire

### design/fir_pcm_if.sv
`default_nettype none

// input word channel
interface fir_pcm_in_if import fir_pcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [TIDX_W-1:0] tap_index;
  coef_t             coefficient;
  sample_t           sample_in;
  logic              start_of_stream;

  modport source (output valid, command, tap_index, coefficient, sample_in,
                  start_of_stream, input ready);
  modport sink   (input valid, command, tap_index, coefficient, sample_in,
                  start_of_stream, output ready);
endinterface

// result word channel
interface fir_pcm_out_if import fir_pcm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

`default_nettype wire

### design/fir_filter_pcm16.sv
// fir_filter_pcm16: direct-form FIR on signed 16-bit PCM.
// in_if: valid/ready words. command=0 writes coefficient[tap_index] (Q2.15)
//   and gives no result; writes with tap_index >= TAPS drop.
// command=1 filters sample_in; start_of_stream=1 first zeroes the history.
// out_if: valid/ready words with sample_out and saturated. The result is
//   sum(coef[n]*hist[n], n < tap_count), truncated toward zero by 2^15,
//   then clipped to 16 bits (saturated flags the clip).
// cfg_wr_en/cfg_wr_data write tap_count (limited to TAPS); only when idle.
// Timing: one shared 18x16 multiplier, one tap per cycle. After a sample is
//   accepted, in_if.ready stays low until its result is valid. Memory read
//   and product registers lie between a tap's issue and its accumulation.
// Stall: the result sits in an output register; the block goes back to
//   accepting words while it waits, and only holds in the final step if the
//   register is still full when the next result is ready.
// Reset: tap_count=1, all coefficients and history read as zero. Clearing
//   uses per-entry valid bits and a fill count, so no clearing pass is run.
`default_nettype none

`include "fir_filter_pcm16_assert.svh"

module fir_filter_pcm16 import fir_pcm_pkg::*; #(
  parameter int TAPS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  fir_pcm_in_if.sink             in_if,
  fir_pcm_out_if.source          out_if,
  input  wire logic              cfg_wr_en,
  input  wire logic [TCNT_W-1:0] cfg_wr_data
);

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW    = ($clog2(TAPS + 1) > TCNT_W) ? $clog2(TAPS + 1) : TCNT_W;
  localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
  localparam int QW    = ACC_W - FRAC_BITS;

  localparam logic [CW-1:0]        TAPS_C = CW'(TAPS);
  localparam logic [AW-1:0]        LAST_A = AW'(TAPS - 1);
  localparam logic signed [QW-1:0] Q_MAX  = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN  = QW'(-32768);
  localparam logic [ACC_W-1:0]     RND    = ACC_W'((1 << FRAC_BITS) - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [TCNT_W-1:0] tap_count_r;
  logic [CW-1:0]     cnt_r;      // taps in use for this sample
  logic [CW-1:0]     k_r;        // next tap to issue
  logic [CW-1:0]     fill_r;     // history entries written since clear
  logic [AW-1:0]     wr_ptr_r;   // newest history entry
  logic [AW-1:0]     rd_ptr_r;   // history entry for tap k
  logic [TAPS-1:0]   cvalid_r;   // coefficient written since reset

  sample_t           hist_mem [TAPS];
  coef_t             coef_mem [TAPS];
  sample_t           hist_q_r;
  coef_t             coef_q_r;
  logic              hist_ok_r, coef_ok_r, rd_v_r;

  logic signed [QW-1:0] q_r;
  logic                 out_valid_r;
  sample_t              out_sample_r;
  logic                 out_sat_r;

  logic              in_acc, do_filt, do_coef, issue, out_free;
  logic [CW-1:0]     tc_ext, cnt_nxt;
  logic [AW-1:0]     wr_ptr_inc;
  mac_ctrl_t         mac_ctrl;
  logic              mac_busy;
  logic [ACC_W-1:0]  acc, rnd_sum;
  coef_t             mac_coef;
  sample_t           mac_samp;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign do_filt     = in_acc && (in_if.command == CMD_FILTER);
  assign do_coef     = in_acc && (in_if.command == CMD_WRITE_COEF)
                       && (CW'(in_if.tap_index) < TAPS_C);
  assign issue       = (state_r == ST_RUN) && (k_r < cnt_r);
  assign out_free    = !out_valid_r || out_if.ready;

  assign tc_ext     = CW'(tap_count_r);
  assign cnt_nxt    = (tc_ext > TAPS_C) ? TAPS_C : tc_ext;
  assign wr_ptr_inc = (wr_ptr_r == LAST_A) ? '0 : wr_ptr_r + AW'(1);

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TCNT_W'(1);
    end else if (cfg_wr_en) begin
      tap_count_r <= cfg_wr_data;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (do_filt) state_nxt = ST_RUN;
      ST_RUN:   if (!issue && !rd_v_r && !mac_busy) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      wr_ptr_r <= '0;
      cvalid_r <= '0;
      rd_v_r   <= 1'b0;
      k_r      <= '0;
      cnt_r    <= '0;
      rd_ptr_r <= '0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      if (do_coef) begin
        cvalid_r[AW'(in_if.tap_index)] <= 1'b1;
      end
      if (do_filt) begin
        wr_ptr_r <= wr_ptr_inc;
        rd_ptr_r <= wr_ptr_inc;
        k_r      <= '0;
        cnt_r    <= cnt_nxt;
        if (in_if.start_of_stream) begin
          fill_r <= CW'(1);
        end else if (fill_r != TAPS_C) begin
          fill_r <= fill_r + CW'(1);
        end
      end else if (issue) begin
        k_r      <= k_r + CW'(1);
        rd_ptr_r <= (rd_ptr_r == '0) ? LAST_A : rd_ptr_r - AW'(1);
      end
    end
  end

  // history and coefficient memories; reads registered
  always_ff @(posedge clk) begin
    if (do_filt) begin
      hist_mem[wr_ptr_inc] <= in_if.sample_in;
    end
    hist_q_r <= hist_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_coef) begin
      coef_mem[AW'(in_if.tap_index)] <= in_if.coefficient;
    end
    coef_q_r <= coef_mem[k_r[AW-1:0]];
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    hist_ok_r <= (k_r < fill_r);
    coef_ok_r <= cvalid_r[k_r[AW-1:0]];
  end

  assign mac_coef     = coef_ok_r ? coef_q_r : '0;
  assign mac_samp     = hist_ok_r ? hist_q_r : '0;
  assign mac_ctrl.clr = do_filt;
  assign mac_ctrl.vld = rd_v_r;

  fir_pcm_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .coef  (mac_coef),
    .samp  (mac_samp),
    .busy  (mac_busy),
    .acc   (acc)
  );

  // divide by 2^15 toward zero: bias negatives before the shift
  assign rnd_sum = acc + (acc[ACC_W-1] ? RND : '0);

  always_ff @(posedge clk) begin
    if (state_r == ST_ROUND) begin
      q_r <= rnd_sum[ACC_W-1:FRAC_BITS];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      priority if (q_r > Q_MAX) begin
        out_sample_r <= SAMPLE_W'(32767);
        out_sat_r    <= 1'b1;
      end else if (q_r < Q_MIN) begin
        out_sample_r <= sample_t'(Q_MIN[SAMPLE_W-1:0]);
        out_sat_r    <= 1'b1;
      end else begin
        out_sample_r <= q_r[SAMPLE_W-1:0];
        out_sat_r    <= 1'b0;
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;
  assign out_if.saturated  = out_sat_r;

  `FIR_ASSERT(a_k_bound, 1'b1, k_r <= cnt_r, "tap counter past tap count")
  `FIR_ASSERT(a_fill_bound, 1'b1, fill_r <= TAPS_C, "history fill past depth")
  `FIR_ASSERT_NXT(a_filt_run, do_filt, state_r == ST_RUN, "filter word did not start run")
  `FIR_ASSERT_NXT(a_out_hold, out_valid_r && !out_if.ready, out_valid_r && $stable(out_sample_r) && $stable(out_sat_r), "stalled result changed")

endmodule

`default_nettype wire

### design/fir_pcm_mac.sv
`default_nettype none

// Shared multiply-accumulate: registered product, then accumulate.
module fir_pcm_mac import fir_pcm_pkg::*; #(
  parameter int ACC_W = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mac_ctrl_t        ctrl,
  input  wire coef_t            coef,
  input  wire sample_t          samp,
  output logic                  busy,
  output logic [ACC_W-1:0]      acc
);

  prod_t            prod_r;
  logic             mul_v_r;
  logic [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    prod_r <= coef * samp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else begin
      mul_v_r <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign busy = mul_v_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire

### tb/sv/fir_filter_pcm16_tb.sv
`timescale 1ns / 1ps

module fir_filter_pcm16_tb;
  import fir_pcm_pkg::*;

  localparam int TAPS         = 32;
  localparam int TAIL_CYCLES  = 48;      // longest sample plus margin
  localparam int HOLD_CYCLES  = 400;     // long output hold-off
  localparam int LIMIT_CYCLES = 600000;

  // one input word as the block sees it
  typedef struct {
    logic                command;
    logic [TIDX_W-1:0]   tap_index;
    coef_t               coefficient;
    sample_t             sample_in;
    logic                start_of_stream;
  } pcm_word_t;

  // one filtered sample
  typedef struct {
    sample_t pcm;
    logic    clip;
  } pcm_result_t;

  logic clk;
  logic rst_n;
  logic              cfg_wr_en;
  logic [TCNT_W-1:0] cfg_wr_data;

  fir_pcm_in_if  in_ch ();
  fir_pcm_out_if out_ch ();

  fir_filter_pcm16 #(.TAPS(TAPS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // filter state mirror
  sample_t           pcm_history [TAPS];
  coef_t             coef_mem    [TAPS];
  logic [TCNT_W-1:0] active_taps;

  pcm_result_t expected_pcm [$];

  // bookkeeping
  int errors        = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int clips_seen    = 0;
  int taps_written  = 0;
  int holds_done    = 0;
  int cycle_count   = 0;
  bit gaps_on       = 1'b1;   // random idle bursts on both sides
  bit hold_sink     = 1'b0;   // request a long output hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Filter prediction: optional history clear, shift in the new sample,
  // full-precision MAC over the active taps, truncate toward zero by 2^15,
  // then clip to 16 bits.
  function automatic void predict_filter(input pcm_word_t w);
    longint      acc;
    longint      quot;
    int          n_taps;
    pcm_result_t r;
    acc = 0;
    if (w.command == CMD_WRITE_COEF) begin
      coef_mem[w.tap_index] = w.coefficient;  // 5-bit index always fits 32 taps
      return;
    end
    if (w.start_of_stream) begin
      foreach (pcm_history[i]) pcm_history[i] = '0;
    end
    for (int i = TAPS - 1; i > 0; i--) pcm_history[i] = pcm_history[i-1];
    pcm_history[0] = w.sample_in;
    n_taps = (int'(active_taps) > TAPS) ? TAPS : int'(active_taps);
    for (int i = 0; i < n_taps; i++)
      acc += longint'(coef_mem[i]) * longint'(pcm_history[i]);
    quot = acc / (longint'(1) << FRAC_BITS);   // signed divide truncates toward zero
    r.clip = 1'b0;
    if (quot > 32767) begin
      quot   = 32767;
      r.clip = 1'b1;
    end else if (quot < -32768) begin
      quot   = -32768;
      r.clip = 1'b1;
    end
    r.pcm = sample_t'(quot);
    expected_pcm.push_back(r);
  endfunction

  // Drive one word from a falling edge; returns at the falling edge after
  // it was taken. Valid stays high between back-to-back words.
  task automatic send_word(input pcm_word_t w);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.command         <= w.command;
    in_ch.tap_index       <= w.tap_index;
    in_ch.coefficient     <= w.coefficient;
    in_ch.sample_in       <= w.sample_in;
    in_ch.start_of_stream <= w.start_of_stream;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_filter(w);
    words_sent++;
    @(negedge clk);
  endtask

  // coefficient write; sample fields are don't-care and get noise
  task automatic send_coef(input int idx, input int value);
    pcm_word_t w;
    w.command         = CMD_WRITE_COEF;
    w.tap_index       = TIDX_W'(idx);
    w.coefficient     = coef_t'(value);
    w.sample_in       = sample_t'($urandom);
    w.start_of_stream = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  // filter word; tap_index/coefficient are don't-care and get noise
  task automatic send_sample(input int value, input bit sos);
    pcm_word_t w;
    w.command         = CMD_FILTER;
    w.tap_index       = TIDX_W'($urandom_range(0, 31));
    w.coefficient     = coef_t'($urandom);
    w.sample_in       = sample_t'(value);
    w.start_of_stream = sos;
    send_word(w);
  endtask

  // Drop valid, wait for every pending result, then let a trailing
  // coefficient write finish before touching the config port.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_pcm.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // only called from an idle block (after settle)
  task automatic set_taps(input int value);
    cfg_wr_data <= TCNT_W'(value);
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    active_taps = TCNT_W'(value);
    taps_written++;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0:       return -32768;
      1:       return 32767;
      2, 3, 4: return $urandom_range(0, 512) - 256;
      default: return int'(sample_t'($urandom));
    endcase
  endfunction

  // mostly small gains so long filters do not clip on every word
  function automatic int rand_coef();
    case ($urandom_range(0, 9))
      0:          return -131072;
      1:          return 131071;
      2, 3, 4, 5: return $urandom_range(0, 8192) - 4096;
      6, 7:       return $urandom_range(0, 65536) - 32768;
      default:    return int'(coef_t'($urandom));
    endcase
  endfunction

  // After reset: tap_count 1 and zero coefficients, so output is zero.
  task automatic test_reset_state();
    send_sample(12345, 1'b0);
    send_sample(-32768, 1'b1);
  endtask

  // Extreme coefficients and samples, clipping both ways, unity gain at the
  // edges of the range, and truncation toward zero of tiny negative sums.
  task automatic test_directed_corners();
    send_coef(0, 131071);
    send_coef(31, -131072);
    send_sample(32767, 1'b1);
    send_sample(-32768, 1'b0);
    send_coef(0, 32768);      // 1.0
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b0);
    send_coef(0, -1);
    send_sample(1, 1'b0);     // -1/2^15 truncates to 0, not -1
    send_sample(-1, 1'b0);
  endtask

  // Tap count zero (empty sum), 1, full, and above the store size.
  task automatic test_tap_count_extremes();
    int counts [5] = '{0, 1, 32, 33, 63};
    foreach (counts[i]) begin
      settle();
      set_taps(counts[i]);
      send_sample(rand_sample(), 1'b1);
      send_sample(rand_sample(), 1'b0);
    end
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // output register fills and the input stalls; then drain completely.
  task automatic test_output_backpressure();
    settle();
    set_taps(8);
    for (int i = 0; i < 8; i++) send_coef(i, rand_coef());
    hold_sink = 1'b1;
    for (int i = 0; i < 24; i++) send_sample(rand_sample(), i == 0);
    settle();
  endtask

  // One phase: a new tap count, a coefficient load, then a sample stream
  // that normally opens with start_of_stream. Stray clears and coefficient
  // writes land mid-stream now and then.
  task automatic random_phase();
    int n_samp;
    settle();
    case ($urandom_range(0, 9))
      0:       set_taps(0);
      1:       set_taps(1);
      2:       set_taps(32);
      3:       set_taps($urandom_range(33, 63));
      4, 5:    set_taps($urandom_range(1, 8));
      default: set_taps($urandom_range(1, 32));
    endcase
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < TAPS; i++) send_coef(i, rand_coef());
    end else begin
      repeat ($urandom_range(0, 6)) send_coef($urandom_range(0, 31), rand_coef());
    end
    n_samp = $urandom_range(1, 60);
    for (int k = 0; k < n_samp; k++) begin
      if ($urandom_range(0, 19) == 0) send_coef($urandom_range(0, 31), rand_coef());
      if (k == 0) send_sample(rand_sample(), $urandom_range(0, 5) != 0);
      else        send_sample(rand_sample(), $urandom_range(0, 60) == 0);
    end
  endtask

  task automatic test_random_streams(input int n_words);
    int stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) random_phase();
  endtask

  // last stretch: no idle bursts on either side
  task automatic test_full_rate(input int n_words);
    gaps_on = 1'b0;
    test_random_streams(n_words);
  endtask

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_sink = 1'b0;
        holds_done++;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result check against the oldest pending prediction.
  always @(posedge clk) begin : check_results
    pcm_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_pcm.size() == 0) begin
        $display("%0t: unexpected result: sample_out=%0d saturated=%0b",
                 $time, out_ch.sample_out, out_ch.saturated);
        errors++;
      end else begin
        want = expected_pcm.pop_front();
        results_seen++;
        if (want.clip) clips_seen++;
        if (out_ch.sample_out !== want.pcm) begin
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, want.pcm, out_ch.sample_out);
          errors++;
        end
        if (out_ch.saturated !== want.clip) begin
          $display("%0t: saturated mismatch: expected %0b, actual %0b",
                   $time, want.clip, out_ch.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending",
             cycle_count, expected_pcm.size());
    $display("** fir_filter_pcm16: FAILED **");
    $finish;
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    in_ch.valid           = 1'b0;
    in_ch.command         = CMD_FILTER;
    in_ch.tap_index       = '0;
    in_ch.coefficient     = '0;
    in_ch.sample_in       = '0;
    in_ch.start_of_stream = 1'b0;
    foreach (pcm_history[i]) pcm_history[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    active_taps = 1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_directed_corners();
    test_tap_count_extremes();
    test_output_backpressure();
    test_random_streams(1500);
    test_full_rate(300);
    settle();

    $display("covered %0d words in, %0d filtered samples checked, %0d of them clipped",
             words_sent, results_seen, clips_seen);
    $display("tap count set %0d times incl. 0, 1, 32 and above 32; %0d long output hold-offs",
             taps_written, holds_done);
    if (errors == 0) begin
      $display("** fir_filter_pcm16: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** fir_filter_pcm16: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/fir_pcm_pkg.sv
design/fir_pcm_if.sv
design/fir_pcm_mac.sv
design/fir_filter_pcm16.sv
tb/sv/fir_filter_pcm16_tb.sv
